@@ src/arnp_pkg.sv @@
// arnp_pkg: shared types and constants for the receive notice parser
// holds the marker text, the parse phase encoding and the result record
// no dependencies
package arnp_pkg;

   localparam int MARK_LEN = 8;
   localparam int MARK_IDX_WIDTH = 3;
   localparam int OUT_WIDTH = 16;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_K     = 8'h4B;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'b001,
      PH_SOCKET = 3'b010,
      PH_LENGTH = 3'b100
   } phase_type;

   typedef struct packed {
      logic                 notice_found;
      logic [OUT_WIDTH-1:0] socket_number;
      logic [OUT_WIDTH-1:0] message_length;
      logic                 ok_seen;
   } result_type;

   // "+NSONMI:" one character per index
   function automatic logic [7:0] mark_char(input logic [MARK_IDX_WIDTH-1:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = CHAR_PLUS;
         3'd1: c = 8'h4E;
         3'd2: c = 8'h53;
         3'd3: c = 8'h4F;
         3'd4: c = 8'h4E;
         3'd5: c = 8'h4D;
         3'd6: c = 8'h49;
         3'd7: c = 8'h3A;
         default: c = CHAR_PLUS;
      endcase
      return c;
   endfunction

endpackage

@@ src/at_receive_notice_parser.sv @@
// at_receive_notice_parser: top level of the receive notice parser
// input register, arnp_parse next-state logic and the result register
// depends on arnp_pkg and arnp_parse
//
// Usage:
//   The request channel carries one response byte per request with a
//   flag marking the final byte of a response. Only a final byte gives a
//   result on the rsp_ channel: marker found, socket number, message
//   length and the ok flag. Other bytes give no result.
//   A final byte's result passes through the input register, then the
//   result register.
//   Throughput: one byte per cycle. Non-final bytes keep flowing while a
//   result waits on a stalled receiver; only a final byte waits in the
//   input register until the result register is free.
//   Reset (synchronous, active high) empties both registers and returns
//   the parser to searching for the marker with all counts cleared.
//   A stalled result holds its payload until taken.
module at_receive_notice_parser
   import arnp_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_notice_found,
   output logic [15:0] rsp_socket_number,
   output logic [15:0] rsp_message_length,
   output logic        rsp_ok_seen
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   result_type parse_result;
   logic       req_accept, rsp_taken, s1_blocked, s1_advance, rsp_load;

   always_comb begin
      rsp_taken   = rsp_valid_ff && !rsp_stall;
      s1_blocked  = s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall;
      s1_advance  = s1_valid_ff && !s1_blocked;
      rsp_load    = s1_advance && s1_last_ff;
      req_stall   = s1_blocked;
      req_accept  = req_valid && !s1_blocked;

      s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_byte_in  = req_accept ? req_rx_byte : s1_byte_ff;
      s1_last_in  = req_accept ? req_last_byte : s1_last_ff;

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_taken ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_load ? parse_result : rsp_data_ff;
   end

   arnp_parse #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_advance),
      .rx_byte   (s1_byte_ff),
      .last_byte (s1_last_ff),
      .result    (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_notice_found   = rsp_data_ff.notice_found;
   assign rsp_socket_number  = rsp_data_ff.socket_number;
   assign rsp_message_length = rsp_data_ff.message_length;
   assign rsp_ok_seen        = rsp_data_ff.ok_seen;

   a_rsp_from_last_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a final byte");

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff))
      else $error("request stalled without a waiting final byte");

   a_no_marker_zero_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.notice_found) |->
         (rsp_data_ff.socket_number == '0 && rsp_data_ff.message_length == '0))
      else $error("counts nonzero without marker");

endmodule

@@ src/arnp_parse.sv @@
// arnp_parse: per-byte parser state and its next-state logic
// tracks marker match, socket and length accumulators and the ok flag
// depends on arnp_pkg
module arnp_parse
   import arnp_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   input  logic       last_byte,
   output result_type result
);

   localparam int SUM_WIDTH = COUNT_WIDTH + 4;
   localparam int WIDE_WIDTH = COUNT_WIDTH + OUT_WIDTH;

   logic [MARK_IDX_WIDTH-1:0] match_pos_ff, match_pos_in;
   phase_type                 phase_ff, phase_in, phase_nxt;
   logic [COUNT_WIDTH-1:0]    socket_acc_ff, socket_acc_in, socket_nxt;
   logic [COUNT_WIDTH-1:0]    length_acc_ff, length_acc_in, length_nxt;
   logic                      prev_was_o_ff, prev_was_o_in;
   logic                      ok_flag_ff, ok_flag_in, ok_nxt;
   logic [MARK_IDX_WIDTH-1:0] match_nxt;
   logic                      is_digit;
   logic                      found;
   logic [COUNT_WIDTH-1:0]    sock_val, len_val;

   function automatic logic [COUNT_WIDTH-1:0] add_digit(
      input logic [COUNT_WIDTH-1:0] acc,
      input logic [3:0]             d
   );
      logic [SUM_WIDTH-1:0] v;
      v = SUM_WIDTH'({acc, 3'b000}) + SUM_WIDTH'({acc, 1'b0}) + SUM_WIDTH'(d);
      if (v > SUM_WIDTH'({COUNT_WIDTH{1'b1}}))
         return {COUNT_WIDTH{1'b1}};
      return v[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_WIDTH-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
      logic [WIDE_WIDTH-1:0] w;
      w = WIDE_WIDTH'(v);
      if (w > WIDE_WIDTH'({OUT_WIDTH{1'b1}}))
         return {OUT_WIDTH{1'b1}};
      return w[OUT_WIDTH-1:0];
   endfunction

   always_comb begin
      is_digit   = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
      ok_nxt     = ok_flag_ff | (prev_was_o_ff && (rx_byte == CHAR_K));
      match_nxt  = match_pos_ff;
      phase_nxt  = phase_ff;
      socket_nxt = socket_acc_ff;
      length_nxt = length_acc_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (rx_byte == mark_char(match_pos_ff)) begin
               if (match_pos_ff == MARK_IDX_WIDTH'(MARK_LEN - 1)) begin
                  match_nxt = '0;
                  phase_nxt = PH_SOCKET;
               end else begin
                  match_nxt = match_pos_ff + 1'b1;
               end
            end else begin
               match_nxt = (rx_byte == CHAR_PLUS) ? MARK_IDX_WIDTH'(1) : '0;
            end
         end
         PH_SOCKET: begin
            if (is_digit)
               socket_nxt = add_digit(socket_acc_ff, rx_byte[3:0]);
            else if (rx_byte == CHAR_COMMA)
               phase_nxt = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (is_digit)
               length_nxt = add_digit(length_acc_ff, rx_byte[3:0]);
         end
         default: begin
            phase_nxt = PH_SEARCH;
         end
      endcase

      found    = (phase_nxt != PH_SEARCH);
      sock_val = found ? socket_nxt : '0;
      case (phase_nxt)
         PH_SOCKET: len_val = socket_nxt;
         PH_LENGTH: len_val = length_nxt;
         default:   len_val = '0;
      endcase
      result.notice_found   = found;
      result.socket_number  = clamp_out(sock_val);
      result.message_length = clamp_out(len_val);
      result.ok_seen        = ok_nxt;
   end

   always_comb begin
      match_pos_in  = match_pos_ff;
      phase_in      = phase_ff;
      socket_acc_in = socket_acc_ff;
      length_acc_in = length_acc_ff;
      prev_was_o_in = prev_was_o_ff;
      ok_flag_in    = ok_flag_ff;
      if (advance) begin
         if (last_byte) begin
            match_pos_in  = '0;
            phase_in      = PH_SEARCH;
            socket_acc_in = '0;
            length_acc_in = '0;
            prev_was_o_in = 1'b0;
            ok_flag_in    = 1'b0;
         end else begin
            match_pos_in  = match_nxt;
            phase_in      = phase_nxt;
            socket_acc_in = socket_nxt;
            length_acc_in = length_nxt;
            prev_was_o_in = (rx_byte == CHAR_O);
            ok_flag_in    = ok_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_pos_ff  <= '0;
         phase_ff      <= PH_SEARCH;
         socket_acc_ff <= '0;
         length_acc_ff <= '0;
         prev_was_o_ff <= 1'b0;
         ok_flag_ff    <= 1'b0;
      end else begin
         match_pos_ff  <= match_pos_in;
         phase_ff      <= phase_in;
         socket_acc_ff <= socket_acc_in;
         length_acc_ff <= length_acc_in;
         prev_was_o_ff <= prev_was_o_in;
         ok_flag_ff    <= ok_flag_in;
      end
   end

   a_match_idle_after_marker: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_SEARCH) |-> (match_pos_ff == '0))
      else $error("marker match position not cleared after marker");

   a_acc_clear_while_search: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEARCH) |-> (socket_acc_ff == '0 && length_acc_ff == '0))
      else $error("accumulators nonzero before marker");

   a_length_clear_in_socket: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SOCKET) |-> (length_acc_ff == '0))
      else $error("length accumulator nonzero before comma");

endmodule

@@ verif/tb_at_receive_notice_parser.sv @@
// tb_at_receive_notice_parser: self-checking testbench for the receive notice parser
// random and directed response bytes, an in-bench parser model and a result scoreboard
// depends on arnp_pkg and at_receive_notice_parser
module tb_at_receive_notice_parser
   import arnp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER = 150;
   localparam logic [8*MARK_LEN-1:0] MARK_TEXT = "+NSONMI:";

   typedef struct {
      logic [7:0] rx_byte;
      logic       last_byte;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_notice_found;
   logic [15:0] rsp_socket_number;
   logic [15:0] rsp_message_length;
   logic        rsp_ok_seen;

   request_type request_queue[$];
   result_type  expected_notices[$];

   // parser model state
   logic [3:0]  marker_pos = '0;
   phase_type   phase = PH_SEARCH;
   logic [15:0] socket_count = '0;
   logic [15:0] length_count = '0;
   logic        last_was_o = 1'b0;
   logic        ok_found = 1'b0;

   int fail_count = 0;
   int accepted_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int send_calm = 0;
   int stall_left = 0;
   int stall_calm = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int frame_count = 0;

   at_receive_notice_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_notice_found(rsp_notice_found),
      .rsp_socket_number(rsp_socket_number),
      .rsp_message_length(rsp_message_length),
      .rsp_ok_seen(rsp_ok_seen)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] add_decimal(input logic [15:0] acc, input logic [7:0] b);
      int unsigned v;
      v = int'(acc) * 10 + int'(b - CHAR_ZERO);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic last);
      int p;
      logic is_digit;
      result_type notice;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      if (last_was_o && b == CHAR_K) ok_found = 1'b1;
      last_was_o = (b == CHAR_O);
      case (phase)
         PH_SEARCH: begin
            p = int'(marker_pos);
            if (p < MARK_LEN && b == MARK_TEXT[8*(MARK_LEN-1-p) +: 8]) p = p + 1;
            else p = (b == CHAR_PLUS) ? 1 : 0;
            if (p >= MARK_LEN) begin
               phase = PH_SOCKET;
               p = 0;
            end
            marker_pos = p[3:0];
         end
         PH_SOCKET: begin
            if (is_digit) socket_count = add_decimal(socket_count, b);
            else if (b == CHAR_COMMA) phase = PH_LENGTH;
         end
         default: begin
            if (is_digit) length_count = add_decimal(length_count, b);
         end
      endcase
      if (last) begin
         notice.notice_found = (phase != PH_SEARCH);
         notice.socket_number = notice.notice_found ? socket_count : 16'h0000;
         if (phase == PH_SOCKET) notice.message_length = socket_count;
         else if (phase == PH_LENGTH) notice.message_length = length_count;
         else notice.message_length = 16'h0000;
         notice.ok_seen = ok_found;
         expected_notices.push_back(notice);
         marker_pos = '0;
         phase = PH_SEARCH;
         socket_count = '0;
         length_count = '0;
         last_was_o = 1'b0;
         ok_found = 1'b0;
      end
   endtask

   task automatic check_notice();
      result_type want;
      if (expected_notices.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected notice: found %0b socket %0d length %0d ok %0b",
                     rsp_notice_found, rsp_socket_number, rsp_message_length, rsp_ok_seen);
         return;
      end
      want = expected_notices.pop_front();
      if (rsp_notice_found !== want.notice_found || rsp_socket_number !== want.socket_number ||
          rsp_message_length !== want.message_length || rsp_ok_seen !== want.ok_seen) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"notice mismatch: exp found %0b socket %0d length %0d ok %0b, ",
                      "got %0b %0d %0d %0b"},
                     want.notice_found, want.socket_number, want.message_length, want.ok_seen,
                     rsp_notice_found, rsp_socket_number, rsp_message_length, rsp_ok_seen);
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      request_type r;
      r.rx_byte = b;
      r.last_byte = 1'b0;
      request_queue.push_back(r);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_digits(input int n);
      for (int i = 0; i < n; i++) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic close_response(input int start_size);
      if (request_queue.size() == start_size) push_byte(8'($urandom_range(0, 255)));
      request_queue[request_queue.size()-1].last_byte = 1'b1;
      frame_count++;
   endtask

   task automatic add_random_response();
      int start_size;
      int k;
      start_size = request_queue.size();
      if ($urandom_range(0, 9) < 2) begin
         // noise, leaning toward the interesting characters
         k = $urandom_range(1, 12);
         for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 5))
               0: push_byte(CHAR_O);
               1: push_byte(CHAR_K);
               2: push_byte(CHAR_PLUS);
               default: push_byte(8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         if ($urandom_range(0, 1) == 0) push_text("\r\n");
         if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, MARK_LEN - 1);
            for (int i = 0; i < k; i++) push_byte(MARK_TEXT[8*(MARK_LEN-1-i) +: 8]);
            if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) != 0) push_text("+NSONMI:");
         push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) != 0) begin
            push_byte(CHAR_COMMA);
            push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3));
         end
         case ($urandom_range(0, 5))
            0: push_text("\r\n\r\nOK\r\n");
            1: push_text("\r\n");
            2: push_text(",+NSONMI:12,3");
            3: push_text("O");
            4: push_byte(8'($urandom_range(0, 255)));
            default: ;
         endcase
      end
      close_response(start_size);
   endtask

   initial begin
      // directed: lone byte, marker ending on the last byte after a broken start,
      // ok plus saturating socket with no comma
      close_response(request_queue.size());
      request_queue[request_queue.size()-1].rx_byte = 8'h00;
      push_text("++NSONMI:");
      close_response(request_queue.size());
      push_text("OK+NSONMI:999999");
      close_response(request_queue.size());
      while (request_queue.size() < 626 || frame_count < 40) add_random_response();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (request_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_notices.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte, req_last_byte);
            accepted_count <= accepted_count + 1;
         end
         if (send_calm != 0) send_calm <= send_calm - 1;
         else if ($urandom_range(0, 49) == 0) send_calm <= $urandom_range(30, 90);
         if (req_valid && req_stall) begin
            // payload held until taken
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= request_queue[0].rx_byte;
            req_last_byte <= request_queue[0].last_byte;
            void'(request_queue.pop_front());
            send_gap <= (send_calm != 0) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_notice();
         if (stall_calm != 0) stall_calm <= stall_calm - 1;
         else if ($urandom_range(0, 49) == 0) stall_calm <= $urandom_range(30, 90);
         if (stall_left != 0) stall_left <= stall_left - 1;
         else stall_left <= (stall_calm != 0) ? 0 : pick_gap();
         rsp_stall <= (hold_left != 0) || (stall_left != 0);
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
